// File: design/i2cram_pkg.sv
// Shared types, constants and byte selection for the I2C register access master.
package i2cram_pkg;

    localparam int unsigned I2CRAM_ACK_POLL_LIMIT = 300;
    localparam int unsigned I2CRAM_POLL_W         = 9;
    localparam logic [6:0]  I2CRAM_DEV_ADDR_RESET = 7'd72;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  register_pointer;
        logic [15:0] write_value;
        logic        sda_sample;
    } i2cram_in_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_enable;
        logic        busy_res;
        logic        done_res;
        logic        nack_seen;
        logic [15:0] read_value;
    } i2cram_out_t;

    // Byte sent at a given step: address+W, pointer, then data high or address+R, data low.
    function automatic logic [7:0] byte_to_send(
        input logic [2:0]  step,
        input logic [6:0]  dev_addr,
        input logic [7:0]  pointer,
        input logic [15:0] data,
        input logic        rd
    );
        logic [7:0] addr;
        logic [7:0] sel;
        addr = {dev_addr, 1'b0};
        case (step)
            3'd0:    sel = addr;
            3'd1:    sel = pointer;
            3'd2:    sel = rd ? (addr | 8'h01) : data[15:8];
            default: sel = data[7:0];
        endcase
        return sel;
    endfunction

endpackage

// File: design/i2cram_seq.sv
// Bus tick sequencer: state registers and next-state logic for one tick per fire.
module i2cram_seq
    import i2cram_pkg::*;
#(
    parameter int unsigned ACK_POLL_LIMIT = I2CRAM_ACK_POLL_LIMIT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  i2cram_in_t  beat,
    input  logic [6:0]  dev_addr,
    output i2cram_out_t result
);

    localparam logic [4:0] P_IDLE  = 5'd0;
    localparam logic [4:0] P_ST1   = 5'd1;
    localparam logic [4:0] P_ST2   = 5'd2;
    localparam logic [4:0] P_ST3   = 5'd3;
    localparam logic [4:0] P_WLO   = 5'd4;
    localparam logic [4:0] P_WHI   = 5'd5;
    localparam logic [4:0] P_WEND  = 5'd6;
    localparam logic [4:0] P_ACKW  = 5'd7;
    localparam logic [4:0] P_ACKL  = 5'd8;
    localparam logic [4:0] P_RPREP = 5'd9;
    localparam logic [4:0] P_RHI   = 5'd10;
    localparam logic [4:0] P_RLO   = 5'd11;
    localparam logic [4:0] P_MA1   = 5'd12;
    localparam logic [4:0] P_MA2   = 5'd13;
    localparam logic [4:0] P_MA3   = 5'd14;
    localparam logic [4:0] P_SP1   = 5'd15;
    localparam logic [4:0] P_SP2   = 5'd16;
    localparam logic [4:0] P_SP3   = 5'd17;

    localparam logic [I2CRAM_POLL_W:0] POLL_LIMIT = (I2CRAM_POLL_W + 1)'(ACK_POLL_LIMIT);
    localparam logic                   POLL_EARLY = (ACK_POLL_LIMIT > 1);

    logic [4:0]               phase_reg,     phase_next;
    logic [2:0]               step_reg,      step_next;
    logic [3:0]               bits_reg,      bits_next;
    logic [7:0]               shift_reg,     shift_next;
    logic [15:0]              rdata_reg,     rdata_next;
    logic [7:0]               pointer_reg,   pointer_next;
    logic [15:0]              wdata_reg,     wdata_next;
    logic                     is_read_reg,   is_read_next;
    logic [I2CRAM_POLL_W-1:0] polls_reg,     polls_next;
    logic                     nack_reg,      nack_next;

    always_comb
    begin
        logic [4:0]               ph;
        logic                     scl;
        logic                     sda;
        logic                     en;
        logic                     busy;
        logic                     done;
        logic [3:0]               bc_inc;
        logic [2:0]               st_inc;
        logic [I2CRAM_POLL_W-1:0] pl_inc;

        phase_next   = phase_reg;
        step_next    = step_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        rdata_next   = rdata_reg;
        pointer_next = pointer_reg;
        wdata_next   = wdata_reg;
        is_read_next = is_read_reg;
        polls_next   = polls_reg;
        nack_next    = nack_reg;
        scl  = 1'b1;
        sda  = 1'b1;
        en   = 1'b1;
        busy = 1'b1;
        done = 1'b0;

        ph = phase_reg;
        // command is taken only on an idle tick; same tick runs as first start tick
        if (ph == P_IDLE && (beat.mode == MODE_WRITE || beat.mode == MODE_READ))
        begin
            is_read_next = (beat.mode == MODE_READ);
            pointer_next = beat.register_pointer;
            wdata_next   = beat.write_value;
            step_next    = 3'd0;
            bits_next    = 4'd0;
            polls_next   = '0;
            nack_next    = 1'b0;
            if (beat.mode == MODE_READ)
            begin
                rdata_next = 16'd0;
            end
            ph = P_ST1;
        end

        bc_inc = bits_next + 4'd1;
        st_inc = step_next + 3'd1;
        pl_inc = polls_next + 1'b1;

        case (ph)
            P_ST1:
            begin
                phase_next = P_ST2;
            end
            P_ST2:
            begin
                sda = 1'b0;
                phase_next = P_ST3;
            end
            P_ST3:
            begin
                scl = 1'b0;
                sda = 1'b0;
                shift_next = byte_to_send(step_next, dev_addr, pointer_next, wdata_next,
                                          is_read_next);
                bits_next  = 4'd0;
                polls_next = '0;
                phase_next = P_WLO;
            end
            P_WLO:
            begin
                scl = 1'b0;
                sda = shift_reg[7];
                phase_next = P_WHI;
            end
            P_WHI:
            begin
                sda = shift_reg[7];
                shift_next = {shift_reg[6:0], 1'b0};
                bits_next  = bc_inc;
                phase_next = (bc_inc >= 4'd8) ? P_WEND : P_WLO;
            end
            P_WEND:
            begin
                scl = 1'b0;
                en  = 1'b0;
                phase_next = P_ACKW;
            end
            P_ACKW:
            begin
                en = 1'b0;
                if (POLL_EARLY && !beat.sda_sample)
                begin
                    phase_next = P_ACKL;
                end
                else
                begin
                    polls_next = pl_inc;
                    if ({1'b0, pl_inc} + 1'b1 >= POLL_LIMIT)
                    begin
                        nack_next  = 1'b1;
                        phase_next = P_ACKL;
                    end
                end
            end
            P_ACKL:
            begin
                scl = 1'b0;
                sda = 1'b0;
                step_next = st_inc;
                if ((is_read_reg && st_inc == 3'd2) || (!is_read_reg && st_inc >= 3'd4))
                begin
                    phase_next = P_SP1;
                end
                else if (is_read_reg && st_inc >= 3'd3)
                begin
                    bits_next  = 4'd0;
                    phase_next = P_RPREP;
                end
                else
                begin
                    shift_next = byte_to_send(st_inc, dev_addr, pointer_reg, wdata_reg,
                                              is_read_reg);
                    bits_next  = 4'd0;
                    polls_next = '0;
                    phase_next = P_WLO;
                end
            end
            P_RPREP:
            begin
                scl = 1'b0;
                en  = 1'b0;
                bits_next  = 4'd0;
                phase_next = P_RHI;
            end
            P_RHI:
            begin
                en = 1'b0;
                rdata_next = {rdata_reg[14:0], beat.sda_sample};
                bits_next  = bc_inc;
                phase_next = P_RLO;
            end
            P_RLO:
            begin
                scl = 1'b0;
                en  = 1'b0;
                phase_next = (bits_reg >= 4'd8) ? P_MA1 : P_RHI;
            end
            P_MA1, P_MA2, P_MA3:
            begin
                // master ack on the first read byte, nack on the last
                scl = (ph == P_MA2);
                sda = (step_reg >= 3'd4);
                if (ph == P_MA3)
                begin
                    step_next = st_inc;
                    if (st_inc == 3'd4)
                    begin
                        bits_next  = 4'd0;
                        phase_next = P_RPREP;
                    end
                    else
                    begin
                        phase_next = P_SP1;
                    end
                end
                else
                begin
                    phase_next = ph + 5'd1;
                end
            end
            P_SP1:
            begin
                scl = 1'b0;
                sda = 1'b0;
                phase_next = P_SP2;
            end
            P_SP2:
            begin
                sda = 1'b0;
                phase_next = P_SP3;
            end
            P_SP3:
            begin
                // after the pointer phase of a read, go straight to the repeated start
                if (is_read_reg && step_reg == 3'd2)
                begin
                    phase_next = P_ST1;
                end
                else
                begin
                    done = 1'b1;
                    phase_next = P_IDLE;
                end
            end
            default:
            begin
                busy = 1'b0;
                phase_next = P_IDLE;
            end
        endcase

        if (!en)
        begin
            sda = 1'b1;
        end

        result.scl_level  = scl;
        result.sda_level  = sda;
        result.sda_enable = en;
        result.busy_res   = busy;
        result.done_res   = done;
        result.nack_seen  = nack_next;
        result.read_value = rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            step_reg    <= '0;
            bits_reg    <= '0;
            shift_reg   <= '0;
            rdata_reg   <= '0;
            pointer_reg <= '0;
            wdata_reg   <= '0;
            is_read_reg <= 1'b0;
            polls_reg   <= '0;
            nack_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            bits_reg    <= bits_next;
            shift_reg   <= shift_next;
            rdata_reg   <= rdata_next;
            pointer_reg <= pointer_next;
            wdata_reg   <= wdata_next;
            is_read_reg <= is_read_next;
            polls_reg   <= polls_next;
            nack_reg    <= nack_next;
        end
    end

endmodule

// File: design/i2c_register_access_master_core.sv
// Top level of the I2C register access master: input stage, sequencer, result register.
//
// Usage:
//   in channel  (in_valid / in_stall / in_beat): one beat per prescaled bus tick. Each
//     beat carries the sampled SDA level; on an idle tick a mode of register write or
//     register read starts a transaction, and the pointer and write value are latched.
//     Other command fields are ignored while a transaction is running.
//   out channel (out_valid / out_stall / out_beat): exactly one result beat per input
//     beat, in order: SCL and SDA drive levels, SDA enable, busy, done, sticky nack and
//     the 16-bit read value.
//   cfg port (cfg_wr_en / cfg_wr_data): writes the 7-bit device address; write it only
//     while no transaction is in flight.
// Path: an accepted beat is held in the input register, then the sequencer step writes
//   its result into the result register; an out_stall can hold it in between.
// Throughput: one beat per cycle when out_stall is low; the sequencer takes one tick per
//   cycle, and the result register lets a new beat in as the previous result is taken.
// Reset: the bus goes idle (SCL high, SDA driven high), the sequencer state clears and
//   the device address returns to 72.
// Stall: an out_stall holds the result register; the input register then holds too and
//   in_stall rises once it is full, so no beat is lost or repeated.
module i2c_register_access_master_core
    import i2cram_pkg::*;
#(
    parameter int unsigned ACK_POLL_LIMIT = I2CRAM_ACK_POLL_LIMIT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  i2cram_in_t  in_beat,
    output logic        out_valid,
    input  logic        out_stall,
    output i2cram_out_t out_beat,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);

    logic        dev_addr_reg;
    logic [6:0]  dev_address_reg;
    logic        s1_valid_reg;
    i2cram_in_t  s1_beat_reg;
    logic        out_valid_reg;
    i2cram_out_t out_beat_reg;
    logic        advance;
    logic        accept;
    logic        fire;
    i2cram_out_t step_result;

    // result register free, or emptied this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    // device address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_address_reg <= I2CRAM_DEV_ADDR_RESET;
            dev_addr_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            dev_address_reg <= cfg_wr_data;
            dev_addr_reg    <= 1'b1;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg <= in_beat;
        end
    end

    i2cram_seq #(
        .ACK_POLL_LIMIT (ACK_POLL_LIMIT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .beat     (s1_beat_reg),
        .dev_addr (dev_address_reg),
        .result   (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_beat_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // a held input beat stays in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("input beat dropped while result register full");

    // a released SDA always reads back as high
    a_sda_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_beat_reg.sda_enable) |-> out_beat_reg.sda_level)
        else $error("sda level low while released");

    // done only on a busy tick, and an idle tick keeps SCL high
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_beat_reg.busy_res) |->
            (!out_beat_reg.done_res && out_beat_reg.scl_level))
        else $error("done or scl low on an idle tick");

    // a result is produced only from a beat that sat in the input register
    a_fire_src: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result beat without input beat");

    // a write enable always loads the written address into the address register
    a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (dev_addr_reg && dev_address_reg == $past(cfg_wr_data)))
        else $error("device address not taken");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the I2C register access master core.
module testbench;
    import i2cram_pkg::*;

    // Mode code with no meaning; the core must treat it as no command.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // How the fake slave answers each ack poll.
    localparam int ACK_RANDOM        = 0;
    localparam int ACK_PROMPT        = 1;
    localparam int ACK_FIRST_TIMEOUT = 2;

    // What the fake slave puts on SDA while the master reads.
    localparam int DATA_RANDOM = 0;
    localparam int DATA_ZEROS  = 1;
    localparam int DATA_ONES   = 2;

    // Cycles without any beat moving on either side before we give up.
    localparam int STUCK_LIMIT = 1000;
    // Random ticks on top of the directed part; the last stretch runs with no input gaps or stalls.
    localparam int RANDOM_TICKS = 400;
    localparam int CALM_TICKS   = 150;
    localparam int CFG_SPACING  = 200;

    // Bus sequencer phases, mirrored in the predictor below.
    typedef enum logic [5:0] {
        PH_IDLE,
        PH_START1,
        PH_START2,
        PH_START3,
        PH_SEND_LO,
        PH_SEND_HI,
        PH_SEND_END,
        PH_ACK_WAIT,
        PH_ACK_LOW,
        PH_READ_PREP,
        PH_READ_HI,
        PH_READ_LO,
        PH_MACK1,
        PH_MACK2,
        PH_MACK3,
        PH_STOP1,
        PH_STOP2,
        PH_STOP3
    } bus_phase_e;

    // Bus sequencer predictor plus the queue of bus ticks still owed by the core.
    class i2c_scoreboard;
        logic [6:0]  dev_addr;
        bus_phase_e  phase;
        logic [2:0]  byte_step;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] read_acc;
        logic [7:0]  ptr_latch;
        logic [15:0] data_latch;
        logic        rd_latch;
        logic [8:0]  polls;
        logic        nack;
        i2cram_out_t pending_q[$];
        int          errors;

        function new();
            dev_addr   = I2CRAM_DEV_ADDR_RESET;
            phase      = PH_IDLE;
            byte_step  = '0;
            bit_count  = '0;
            shift_byte = '0;
            read_acc   = '0;
            ptr_latch  = '0;
            data_latch = '0;
            rd_latch   = 1'b0;
            polls      = '0;
            nack       = 1'b0;
            errors     = 0;
        endfunction

        // Address+W, pointer, then data high (write) or address+R (read), data low.
        function logic [7:0] outgoing_byte(logic [2:0] k);
            logic [7:0] addr_w;
            addr_w = {dev_addr, 1'b0};
            case (k)
                3'd0:    return addr_w;
                3'd1:    return ptr_latch;
                3'd2:    return rd_latch ? (addr_w | 8'h01) : data_latch[15:8];
                default: return data_latch[7:0];
            endcase
        endfunction

        function void load_next_byte();
            shift_byte = outgoing_byte(byte_step);
            bit_count  = '0;
            polls      = '0;
            phase      = PH_SEND_LO;
        endfunction

        // One bus tick: drive levels and state update for one accepted input beat.
        function i2cram_out_t bus_tick(i2cram_in_t b);
            logic        scl;
            logic        sda;
            logic        en;
            logic        busy;
            logic        done;
            logic        ack_bit;
            i2cram_out_t r;
            scl  = 1'b1;
            sda  = 1'b1;
            en   = 1'b1;
            busy = 1'b1;
            done = 1'b0;

            if (phase == PH_IDLE && (b.mode == MODE_WRITE || b.mode == MODE_READ))
            begin
                rd_latch   = (b.mode == MODE_READ);
                ptr_latch  = b.register_pointer;
                data_latch = b.write_value;
                byte_step  = '0;
                bit_count  = '0;
                polls      = '0;
                nack       = 1'b0;
                if (rd_latch)
                    read_acc = '0;
                phase = PH_START1;
            end

            // master ack on the first read byte, nack on the last
            ack_bit = (byte_step >= 3'd4);

            case (phase)
                PH_IDLE:
                    busy = 1'b0;
                PH_START1:
                    phase = PH_START2;
                PH_START2:
                begin
                    sda   = 1'b0;
                    phase = PH_START3;
                end
                PH_START3:
                begin
                    scl = 1'b0;
                    sda = 1'b0;
                    load_next_byte();
                end
                PH_SEND_LO:
                begin
                    scl   = 1'b0;
                    sda   = shift_byte[7];
                    phase = PH_SEND_HI;
                end
                PH_SEND_HI:
                begin
                    sda        = shift_byte[7];
                    shift_byte = shift_byte << 1;
                    bit_count  = bit_count + 4'd1;
                    phase      = (bit_count >= 4'd8) ? PH_SEND_END : PH_SEND_LO;
                end
                PH_SEND_END:
                begin
                    scl   = 1'b0;
                    en    = 1'b0;
                    phase = PH_ACK_WAIT;
                end
                PH_ACK_WAIT:
                begin
                    en = 1'b0;
                    if (I2CRAM_ACK_POLL_LIMIT > 1 && b.sda_sample == 1'b0)
                        phase = PH_ACK_LOW;
                    else
                    begin
                        polls = polls + 9'd1;
                        if (int'(polls) + 1 >= int'(I2CRAM_ACK_POLL_LIMIT))
                        begin
                            nack  = 1'b1;
                            phase = PH_ACK_LOW;
                        end
                    end
                end
                PH_ACK_LOW:
                begin
                    scl       = 1'b0;
                    sda       = 1'b0;
                    byte_step = byte_step + 3'd1;
                    if (rd_latch)
                    begin
                        if (byte_step == 3'd2)
                            phase = PH_STOP1;
                        else if (byte_step >= 3'd3)
                        begin
                            bit_count = '0;
                            phase     = PH_READ_PREP;
                        end
                        else
                            load_next_byte();
                    end
                    else if (byte_step >= 3'd4)
                        phase = PH_STOP1;
                    else
                        load_next_byte();
                end
                PH_READ_PREP:
                begin
                    scl       = 1'b0;
                    en        = 1'b0;
                    bit_count = '0;
                    phase     = PH_READ_HI;
                end
                PH_READ_HI:
                begin
                    en        = 1'b0;
                    read_acc  = {read_acc[14:0], b.sda_sample};
                    bit_count = bit_count + 4'd1;
                    phase     = PH_READ_LO;
                end
                PH_READ_LO:
                begin
                    scl   = 1'b0;
                    en    = 1'b0;
                    phase = (bit_count >= 4'd8) ? PH_MACK1 : PH_READ_HI;
                end
                PH_MACK1:
                begin
                    scl   = 1'b0;
                    sda   = ack_bit;
                    phase = PH_MACK2;
                end
                PH_MACK2:
                begin
                    sda   = ack_bit;
                    phase = PH_MACK3;
                end
                PH_MACK3:
                begin
                    scl       = 1'b0;
                    sda       = ack_bit;
                    byte_step = byte_step + 3'd1;
                    if (byte_step == 3'd4)
                    begin
                        bit_count = '0;
                        phase     = PH_READ_PREP;
                    end
                    else
                        phase = PH_STOP1;
                end
                PH_STOP1:
                begin
                    scl   = 1'b0;
                    sda   = 1'b0;
                    phase = PH_STOP2;
                end
                PH_STOP2:
                begin
                    sda   = 1'b0;
                    phase = PH_STOP3;
                end
                PH_STOP3:
                begin
                    // a read turns around with a repeated start after the pointer
                    if (rd_latch && byte_step == 3'd2)
                        phase = PH_START1;
                    else
                    begin
                        done  = 1'b1;
                        phase = PH_IDLE;
                    end
                end
                default:
                    phase = PH_IDLE;
            endcase

            if (!en)
                sda = 1'b1;
            r.scl_level  = scl;
            r.sda_level  = sda;
            r.sda_enable = en;
            r.busy_res   = busy;
            r.done_res   = done;
            r.nack_seen  = nack;
            r.read_value = read_acc;
            return r;
        endfunction

        function void note_tick(i2cram_in_t b);
            pending_q.push_back(bus_tick(b));
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(i2cram_out_t got);
            i2cram_out_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t result beat with nothing expected: %h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            field_check("scl_level",  16'(want.scl_level),  16'(got.scl_level));
            field_check("sda_level",  16'(want.sda_level),  16'(got.sda_level));
            field_check("sda_enable", 16'(want.sda_enable), 16'(got.sda_enable));
            field_check("busy_res",   16'(want.busy_res),   16'(got.busy_res));
            field_check("done_res",   16'(want.done_res),   16'(got.done_res));
            field_check("nack_seen",  16'(want.nack_seen),  16'(got.nack_seen));
            field_check("read_value", want.read_value, got.read_value);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    i2cram_in_t  in_beat;
    logic        out_valid;
    logic        out_stall;
    i2cram_out_t out_beat;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;

    i2c_scoreboard board;
    int            ticks_sent;
    int            gap_odds;   // per transfer: 0 means no input gaps at all
    bit            calm_tail;  // set for the last stretch: no gaps, no stalls

    i2c_register_access_master_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_beat     (in_beat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_beat    (out_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one tick beat, maybe after an idle burst, and hold it until accepted.
    // The predictor advances right at acceptance, so callers can look at its
    // phase to shape the next beat (ack polls, read bits).
    task automatic send_tick(input i2cram_in_t b);
        if (!calm_tail && gap_odds != 0 && $urandom_range(0, 15) < gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_beat  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_tick(b);
        ticks_sent++;
    endtask

    // Ticks on an idle bus carrying no command: mode none or the unused code.
    task automatic send_idle(input int n);
        i2cram_in_t b;
        repeat (n)
        begin
            b.mode             = $urandom_range(0, 1) ? MODE_NONE : MODE_UNUSED;
            b.register_pointer = 8'($urandom);
            b.write_value      = 16'($urandom);
            b.sda_sample       = 1'($urandom);
            send_tick(b);
        end
    endtask

    // One whole register access, from the command tick until the core is idle again.
    // Beats after the first carry random command fields; the core must ignore them.
    task automatic run_transfer(input logic [1:0] mode, input logic [7:0] ptr,
                                input logic [15:0] value, input int ack_style,
                                input int data_style);
        i2cram_in_t b;
        int         ack_wait;
        int         acks_seen;
        int         roll;
        ack_wait  = 0;
        acks_seen = 0;
        gap_odds  = $urandom_range(0, 3);
        b.mode             = mode;
        b.register_pointer = ptr;
        b.write_value      = value;
        b.sda_sample       = 1'($urandom);
        send_tick(b);
        while (board.phase != PH_IDLE)
        begin
            b.mode             = 2'($urandom);
            b.register_pointer = 8'($urandom);
            b.write_value      = 16'($urandom);
            b.sda_sample       = 1'($urandom);
            case (board.phase)
                PH_SEND_END:
                begin
                    // how many high polls the slave makes us wait; 511 forces a timeout
                    roll = $urandom_range(0, 99);
                    if (ack_style == ACK_FIRST_TIMEOUT && acks_seen == 0)
                        ack_wait = 511;
                    else if (ack_style == ACK_PROMPT)
                        ack_wait = 0;
                    else if (roll < 2)
                        ack_wait = 511;
                    else if (roll < 80)
                        ack_wait = $urandom_range(0, 2);
                    else
                        ack_wait = $urandom_range(3, 30);
                    acks_seen++;
                end
                PH_ACK_WAIT:
                    b.sda_sample = (board.polls < ack_wait);
                PH_READ_HI:
                begin
                    if (data_style == DATA_ZEROS)
                        b.sda_sample = 1'b0;
                    else if (data_style == DATA_ONES)
                        b.sda_sample = 1'b1;
                end
                default:
                    ;
            endcase
            send_tick(b);
        end
    endtask

    // Address change only with the core drained: every owed beat in, then a wait to cover
    // the two-stage pipeline.
    task automatic set_address(input logic [6:0] addr);
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_data <= addr;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        board.dev_addr = addr;
    endtask

    // Result side: random stall bursts, quiet stretches, and none in the tail.
    initial
    begin
        int burst;
        int calm;
        bit hold;
        burst = 0;
        calm  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            hold = 1'b0;
            if (burst > 0)
            begin
                hold = 1'b1;
                burst--;
            end
            else if (calm > 0)
                calm--;
            else if (!calm_tail)
            begin
                case ($urandom_range(0, 19))
                    0, 1:    burst = $urandom_range(1, 15);
                    2:       calm = $urandom_range(40, 200);
                    default: ;
                endcase
            end
            if (calm_tail)
            begin
                hold  = 1'b0;
                burst = 0;
            end
            out_stall <= hold;
        end
    end

    // Every accepted result beat goes against the oldest predicted tick.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(out_beat);
        end
    end

    // Watchdog: the run is hung if no beat moves on either side for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int next_cfg;
        int stop_at;
        logic [6:0] addr;
        board       = new();
        ticks_sent  = 0;
        gap_odds    = 0;
        calm_tail   = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_beat     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle-bus commands that do nothing, byte extremes, read data
        // all ones and all zeros, ack timeouts on write and read (sticky nack,
        // then cleared by the next command), both address extremes.
        send_idle(2);
        run_transfer(MODE_WRITE, 8'h00, 16'h0000, ACK_PROMPT, DATA_RANDOM);
        run_transfer(MODE_WRITE, 8'hFF, 16'hFFFF, ACK_RANDOM, DATA_RANDOM);
        run_transfer(MODE_READ,  8'hA5, 16'h1234, ACK_PROMPT, DATA_ONES);
        run_transfer(MODE_READ,  8'h5A, 16'hFFFF, ACK_PROMPT, DATA_ZEROS);
        run_transfer(MODE_WRITE, 8'h3C, 16'hA55A, ACK_FIRST_TIMEOUT, DATA_RANDOM);
        run_transfer(MODE_READ,  8'h81, 16'h0F0F, ACK_FIRST_TIMEOUT, DATA_RANDOM);
        set_address(7'h00);
        run_transfer(MODE_READ,  8'h01, 16'h0000, ACK_PROMPT, DATA_ONES);
        set_address(7'h7F);
        run_transfer(MODE_WRITE, 8'h20, 16'h7FFE, ACK_PROMPT, DATA_RANDOM);
        send_idle(1);

        // Random: whole transfers with random content and slave timing, idle ticks
        // between them, and a new address every couple of hundred ticks.
        stop_at  = ticks_sent + RANDOM_TICKS;
        next_cfg = ticks_sent + CFG_SPACING;
        while (ticks_sent < stop_at)
        begin
            if (ticks_sent >= stop_at - CALM_TICKS)
                calm_tail = 1'b1;
            if (ticks_sent >= next_cfg)
            begin
                case ($urandom_range(0, 3))
                    0:       addr = 7'h00;
                    1:       addr = 7'h7F;
                    default: addr = 7'($urandom);
                endcase
                set_address(addr);
                next_cfg = ticks_sent + CFG_SPACING;
            end
            if ($urandom_range(0, 2) == 0)
                send_idle($urandom_range(1, 3));
            run_transfer($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, 8'($urandom),
                         16'($urandom), ACK_RANDOM, DATA_RANDOM);
        end

        // Drain, then wait for the pipeline to show any stray beat.
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
